### sv/tdchd_pkg.sv
// ----------------------------------------------------------------------------
// tdchd_pkg
// Shared types and constants of the TDC event hit decoder: word classes,
// field widths, controller states, hit store entry and control bundles.
// ----------------------------------------------------------------------------
package tdchd_pkg;

    localparam int MAX_HITS_DEF = 32;
    localparam int NCHAN        = 128;

    localparam int WORD_W     = 32;
    localparam int CLS_W      = 5;
    localparam int CHAN_W     = 7;
    localparam int OUT_CHAN_W = 8;
    localparam int TIME_W     = 19;
    localparam int WIDTH_W    = 20;
    localparam int EVNUM_W    = 22;
    localparam int TAG_W      = 32;
    localparam int HIT_CNT_W  = 6;

    localparam logic [CLS_W-1:0] CLS_MEAS       = 5'h00;
    localparam logic [CLS_W-1:0] CLS_GLOBAL_HDR = 5'h08;
    localparam logic [CLS_W-1:0] CLS_GLOBAL_TRL = 5'h10;
    localparam logic [CLS_W-1:0] CLS_EXT_TAG    = 5'h11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRD_PEND,
        ST_TRD_HIT,
        ST_SUM,
        ST_HIT_OUT
    } state_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  chan;
        logic [TIME_W-1:0]  lead;
        logic [WIDTH_W-1:0] width;
    } hit_entry_t;

    typedef struct packed {
        logic take;
        logic trail_rd;
        logic width_wr;
        logic drain_start;
        logic drain_next;
        logic clear_event;
        logic show_hit;
    } dp_cmd_t;

    typedef struct packed {
        logic trail_hit;
        logic word_last;
        logic hits_zero;
        logic drain_end;
    } dp_status_t;

endpackage

### sv/tdchd_ctrl.sv
// ----------------------------------------------------------------------------
// tdchd_ctrl
// Controller of the decoder: takes words, sequences the trailing-edge
// read-modify-write and drains the summary and stored hits at end of event.
// ----------------------------------------------------------------------------
module tdchd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_last_word,
    input  logic                  m_ready,
    input  tdchd_pkg::dp_status_t status,
    output logic                  s_ready,
    output logic                  m_valid,
    output tdchd_pkg::dp_cmd_t    cmd
);

    tdchd_pkg::state_t state_reg;
    tdchd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tdchd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tdchd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (status.trail_hit) begin
                        state_next = tdchd_pkg::ST_TRD_PEND;
                    end else if (s_last_word) begin
                        state_next = tdchd_pkg::ST_SUM;
                    end
                end
            end
            tdchd_pkg::ST_TRD_PEND: begin
                state_next = tdchd_pkg::ST_TRD_HIT;
            end
            tdchd_pkg::ST_TRD_HIT: begin
                state_next = status.word_last ? tdchd_pkg::ST_SUM : tdchd_pkg::ST_IDLE;
            end
            tdchd_pkg::ST_SUM: begin
                if (m_ready) begin
                    state_next = status.hits_zero ? tdchd_pkg::ST_IDLE
                                                  : tdchd_pkg::ST_HIT_OUT;
                end
            end
            tdchd_pkg::ST_HIT_OUT: begin
                if (m_ready && status.drain_end) begin
                    state_next = tdchd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdchd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready          = (state_reg == tdchd_pkg::ST_IDLE);
        m_valid          = (state_reg == tdchd_pkg::ST_SUM) ||
                           (state_reg == tdchd_pkg::ST_HIT_OUT);
        cmd.take         = s_ready && s_valid;
        cmd.trail_rd     = (state_reg == tdchd_pkg::ST_TRD_PEND);
        cmd.width_wr     = (state_reg == tdchd_pkg::ST_TRD_HIT);
        cmd.show_hit     = (state_reg == tdchd_pkg::ST_HIT_OUT);
        cmd.drain_start  = (state_reg == tdchd_pkg::ST_SUM) && m_ready && !status.hits_zero;
        cmd.drain_next   = cmd.show_hit && m_ready && !status.drain_end;
        cmd.clear_event  = ((state_reg == tdchd_pkg::ST_SUM) && m_ready && status.hits_zero) ||
                           (cmd.show_hit && m_ready && status.drain_end);
    end

endmodule

### sv/tdchd_datapath.sv
// ----------------------------------------------------------------------------
// tdchd_datapath
// Word decode, event registers, pending-edge table and hit store, and the
// result field selection for summary and hit records.
// ----------------------------------------------------------------------------
module tdchd_datapath #(
    parameter int MAX_HITS = tdchd_pkg::MAX_HITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tdchd_pkg::dp_cmd_t                   cmd,
    output tdchd_pkg::dp_status_t                status,
    input  logic [tdchd_pkg::WORD_W-1:0]         s_data_word,
    input  logic                                 s_last_word,
    output logic                                 m_kind,
    output logic [tdchd_pkg::EVNUM_W-1:0]        m_event_number,
    output logic [tdchd_pkg::HIT_CNT_W-1:0]      m_hit_total,
    output logic [tdchd_pkg::TAG_W-1:0]          m_time_tag,
    output logic                                 m_overflow,
    output logic [tdchd_pkg::OUT_CHAN_W-1:0]     m_channel,
    output logic [tdchd_pkg::TIME_W-1:0]         m_lead_time,
    output logic signed [tdchd_pkg::WIDTH_W-1:0] m_pulse_width,
    output logic                                 m_last_result
);

    localparam int IDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;

    logic [tdchd_pkg::CLS_W-1:0]     in_cls;
    logic [tdchd_pkg::CHAN_W-1:0]    in_chan;
    logic [tdchd_pkg::TIME_W-1:0]    in_time;
    logic                            in_trail;
    logic                            is_meas;
    logic                            store_full;
    logic                            lead_take;

    logic [tdchd_pkg::EVNUM_W-1:0]   ev_reg;
    logic [tdchd_pkg::TAG_W-1:0]     tag_reg;
    logic [tdchd_pkg::HIT_CNT_W-1:0] hit_cnt_reg;
    logic                            ovf_reg;
    logic [tdchd_pkg::NCHAN-1:0]     pend_valid_reg;

    logic [tdchd_pkg::TIME_W-1:0]    time_reg;
    logic                            last_reg;
    logic [IDX_W-1:0]                pend_rd_reg;
    logic [IDX_W-1:0]                drain_idx_reg;
    tdchd_pkg::hit_entry_t           store_rd_reg;

    logic [IDX_W-1:0]                pend_idx_mem [tdchd_pkg::NCHAN];
    tdchd_pkg::hit_entry_t           store_mem [MAX_HITS];

    logic                            store_we;
    logic [IDX_W-1:0]                store_waddr;
    tdchd_pkg::hit_entry_t           store_wdata;
    logic                            store_re;
    logic [IDX_W-1:0]                store_raddr;
    logic [tdchd_pkg::WIDTH_W-1:0]   width_new;

    assign in_cls     = s_data_word[31:27];
    assign in_trail   = s_data_word[26];
    assign in_chan    = s_data_word[25:19];
    assign in_time    = s_data_word[18:0];
    assign is_meas    = (in_cls == tdchd_pkg::CLS_MEAS);
    assign store_full = (hit_cnt_reg >= tdchd_pkg::HIT_CNT_W'(MAX_HITS));
    assign lead_take  = cmd.take && is_meas && !in_trail;

    assign status.trail_hit = is_meas && in_trail && pend_valid_reg[in_chan];
    assign status.word_last = last_reg;
    assign status.hits_zero = (hit_cnt_reg == '0);
    assign status.drain_end = ((tdchd_pkg::HIT_CNT_W'(drain_idx_reg) +
                                tdchd_pkg::HIT_CNT_W'(1)) == hit_cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_reg         <= '0;
            tag_reg        <= '0;
            hit_cnt_reg    <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= '0;
        end else if (cmd.clear_event) begin
            tag_reg        <= '0;
            hit_cnt_reg    <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= '0;
        end else if (cmd.take) begin
            case (in_cls)
                tdchd_pkg::CLS_GLOBAL_HDR: begin
                    ev_reg <= s_data_word[26:5];
                end
                tdchd_pkg::CLS_GLOBAL_TRL: begin
                    tag_reg <= tag_reg + tdchd_pkg::TAG_W'(s_data_word[4:0]);
                end
                tdchd_pkg::CLS_EXT_TAG: begin
                    tag_reg <= tag_reg + {s_data_word[26:0], 5'b00000};
                end
                tdchd_pkg::CLS_MEAS: begin
                    if (!in_trail) begin
                        if (!store_full) begin
                            pend_valid_reg[in_chan] <= 1'b1;
                            hit_cnt_reg             <= hit_cnt_reg +
                                                       tdchd_pkg::HIT_CNT_W'(1);
                        end else begin
                            ovf_reg                 <= 1'b1;
                            pend_valid_reg[in_chan] <= 1'b0;
                        end
                    end else begin
                        pend_valid_reg[in_chan] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            time_reg <= in_time;
            last_reg <= s_last_word;
        end
        if (cmd.drain_start) begin
            drain_idx_reg <= '0;
        end else if (cmd.drain_next) begin
            drain_idx_reg <= drain_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (lead_take && !store_full) begin
            pend_idx_mem[in_chan] <= hit_cnt_reg[IDX_W-1:0];
        end
        if (cmd.take && status.trail_hit) begin
            pend_rd_reg <= pend_idx_mem[in_chan];
        end
    end

    assign width_new = {1'b0, time_reg} - {1'b0, store_rd_reg.lead};

    always_comb begin
        store_we    = 1'b0;
        store_waddr = hit_cnt_reg[IDX_W-1:0];
        store_wdata = '{chan: in_chan, lead: in_time, width: '0};
        if (cmd.width_wr) begin
            store_we    = 1'b1;
            store_waddr = pend_rd_reg;
            store_wdata = '{chan: store_rd_reg.chan, lead: store_rd_reg.lead, width: width_new};
        end else if (lead_take && !store_full) begin
            store_we = 1'b1;
        end
    end

    always_comb begin
        store_re = cmd.trail_rd || cmd.drain_start || cmd.drain_next;
        if (cmd.trail_rd) begin
            store_raddr = pend_rd_reg;
        end else if (cmd.drain_start) begin
            store_raddr = '0;
        end else begin
            store_raddr = drain_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[store_waddr] <= store_wdata;
        end
        if (store_re) begin
            store_rd_reg <= store_mem[store_raddr];
        end
    end

    assign m_kind         = cmd.show_hit;
    assign m_event_number = ev_reg;
    assign m_hit_total    = hit_cnt_reg;
    assign m_time_tag     = tag_reg;
    assign m_overflow     = ovf_reg;
    assign m_channel      = cmd.show_hit ?
                            ({1'b0, store_rd_reg.chan} + tdchd_pkg::OUT_CHAN_W'(1)) : '0;
    assign m_lead_time    = cmd.show_hit ? store_rd_reg.lead : '0;
    assign m_pulse_width  = cmd.show_hit ? signed'(store_rd_reg.width) : '0;
    assign m_last_result  = cmd.show_hit ? status.drain_end : status.hits_zero;

endmodule

### sv/tdc_event_hit_decoder_top.sv
// ----------------------------------------------------------------------------
// tdc_event_hit_decoder_top
// Decodes the 32-bit readout words of one TDC event into a summary record
// followed by one record per stored leading-edge hit.
// ----------------------------------------------------------------------------
// Words are taken one per cycle, but not while a trailing edge is paired or
// results drain. A trailing edge that pairs with a pending leading edge is
// handled in order by the pending-index table read, the hit store read and
// the width write-back, which share the single read and write port of each
// memory. On the word marked last the block stops taking words and emits the
// summary, then the stored hits from the hit store read port at one per
// cycle while the sink is ready. Pending marks sit in flip-flop valid bits
// cleared at once, so no clearing pass follows reset or the end of an event.
module tdc_event_hit_decoder_top #(
    parameter int MAX_HITS = tdchd_pkg::MAX_HITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tdchd_pkg::WORD_W-1:0]         s_data_word,
    input  logic                                 s_last_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_kind,
    output logic [tdchd_pkg::EVNUM_W-1:0]        m_event_number,
    output logic [tdchd_pkg::HIT_CNT_W-1:0]      m_hit_total,
    output logic [tdchd_pkg::TAG_W-1:0]          m_time_tag,
    output logic                                 m_overflow,
    output logic [tdchd_pkg::OUT_CHAN_W-1:0]     m_channel,
    output logic [tdchd_pkg::TIME_W-1:0]         m_lead_time,
    output logic signed [tdchd_pkg::WIDTH_W-1:0] m_pulse_width,
    output logic                                 m_last_result
);

    tdchd_pkg::dp_cmd_t    cmd;
    tdchd_pkg::dp_status_t status;

    tdchd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_word (s_last_word),
        .m_ready     (m_ready),
        .status      (status),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .cmd         (cmd)
    );

    tdchd_datapath #(
        .MAX_HITS (MAX_HITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_data_word    (s_data_word),
        .s_last_word    (s_last_word),
        .m_kind         (m_kind),
        .m_event_number (m_event_number),
        .m_hit_total    (m_hit_total),
        .m_time_tag     (m_time_tag),
        .m_overflow     (m_overflow),
        .m_channel      (m_channel),
        .m_lead_time    (m_lead_time),
        .m_pulse_width  (m_pulse_width),
        .m_last_result  (m_last_result)
    );

endmodule

### sv/tdchd_checker.sv
// ----------------------------------------------------------------------------
// tdchd_checker
// Port-level checks of the TDC event hit decoder, bound to the top level.
// ----------------------------------------------------------------------------
module tdchd_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic                                 m_kind,
    input logic [tdchd_pkg::HIT_CNT_W-1:0]      m_hit_total,
    input logic [tdchd_pkg::OUT_CHAN_W-1:0]     m_channel,
    input logic [tdchd_pkg::TIME_W-1:0]         m_lead_time,
    input logic signed [tdchd_pkg::WIDTH_W-1:0] m_pulse_width,
    input logic                                 m_last_result
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_channel) &&
        $stable(m_lead_time) && $stable(m_pulse_width) && $stable(m_last_result))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while results drain");

    a_hits_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_kind && !m_last_result |=> m_valid && m_kind)
        else $error("summary not followed by hit record");

    a_summary_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> m_channel == '0 && m_lead_time == '0 &&
        m_pulse_width == '0 && (m_last_result == (m_hit_total == '0)))
        else $error("bad summary fields");

    a_hit_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> m_channel != '0 && m_hit_total != '0)
        else $error("bad hit record fields");

endmodule

bind tdc_event_hit_decoder_top tdchd_checker u_tdchd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_hit_total   (m_hit_total),
    .m_channel     (m_channel),
    .m_lead_time   (m_lead_time),
    .m_pulse_width (m_pulse_width),
    .m_last_result (m_last_result)
);
